// ----- sv/assert_macros.svh -----
// Assertion macros shared by the attention softmax RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/atsm_pkg.sv -----
// Shared constants, types and the exponential table for the attention softmax block.
// Used by every module of the block except atsm_ram; depends on nothing.
package atsm_pkg;
	localparam int QUERY_ROWS = 4;
	localparam int KEY_ROWS = 64;
	localparam int HEAD_DIM = 64;
	localparam int QS_DEPTH = QUERY_ROWS * HEAD_DIM;
	localparam int KS_DEPTH = KEY_ROWS * HEAD_DIM;
	localparam int BUF_DEPTH = 64;
	localparam int QS_AW = (QS_DEPTH > 1) ? $clog2(QS_DEPTH) : 1;
	localparam int KS_AW = (KS_DEPTH > 1) ? $clog2(KS_DEPTH) : 1;
	localparam int BUF_AW = 6;
	localparam int SCORE_W = 40;
	localparam int WEIGHT_W = 16;
	localparam int SUM_W = 23;
	localparam int ACC_W = 40;
	localparam int QUOT_W = 17;
	localparam int DIV_W = 41;
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW = 2;
	localparam logic [15:0] LOG2E_Q15 = 16'd47274;
	localparam logic [39:0] EXP_LIMIT = 40'h0020000000;

	typedef enum logic [1:0] {
		MODE_LOAD_Q = 2'd0,
		MODE_LOAD_K = 2'd1,
		MODE_LOAD_V = 2'd2,
		MODE_COMPUTE = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic [5:0] row;
		logic [5:0] col;
		logic signed [15:0] value;
	} cmd_t;

	// 2^(-k/16) in Q.16.
	function automatic logic [16:0] exp2_tab(input logic [4:0] k);
		logic [16:0] t;
		case (k)
			5'd0: t = 17'd65536;
			5'd1: t = 17'd62757;
			5'd2: t = 17'd60097;
			5'd3: t = 17'd57549;
			5'd4: t = 17'd55109;
			5'd5: t = 17'd52773;
			5'd6: t = 17'd50535;
			5'd7: t = 17'd48393;
			5'd8: t = 17'd46341;
			5'd9: t = 17'd44376;
			5'd10: t = 17'd42495;
			5'd11: t = 17'd40693;
			5'd12: t = 17'd38968;
			5'd13: t = 17'd37316;
			5'd14: t = 17'd35734;
			5'd15: t = 17'd34219;
			default: t = 17'd32768;
		endcase
		return t;
	endfunction
endpackage

// ----- sv/atsm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for all stores of the attention softmax block; no dependencies.
module atsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- sv/atsm_front.sv -----
// Front end: accepts input transactions, drops out-of-range ones and queues the rest.
// Depends on atsm_pkg.
module atsm_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_valid,
	output logic             s_ready,
	input  atsm_pkg::cmd_t   s_cmd,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output atsm_pkg::cmd_t   cmd
);
	atsm_pkg::cmd_t q_mem [atsm_pkg::CMDQ_DEPTH];
	logic [atsm_pkg::CMDQ_AW-1:0] head_q, tail_q;
	logic [atsm_pkg::CMDQ_AW:0] cnt_q;
	logic in_range, push, pop;

	always_comb begin
		unique case (s_cmd.mode)
			atsm_pkg::MODE_LOAD_Q: in_range = (32'(s_cmd.row) < atsm_pkg::QUERY_ROWS) &&
				(32'(s_cmd.col) < atsm_pkg::HEAD_DIM);
			atsm_pkg::MODE_LOAD_K, atsm_pkg::MODE_LOAD_V:
				in_range = (32'(s_cmd.row) < atsm_pkg::KEY_ROWS) &&
					(32'(s_cmd.col) < atsm_pkg::HEAD_DIM);
			atsm_pkg::MODE_COMPUTE: in_range = 32'(s_cmd.row) < atsm_pkg::QUERY_ROWS;
			default: in_range = 1'b0;
		endcase
	end

	assign s_ready = 32'(cnt_q) < atsm_pkg::CMDQ_DEPTH;
	assign cmd_valid = cnt_q != '0;
	assign cmd = q_mem[head_q];
	assign push = s_valid && s_ready && in_range;
	assign pop = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[tail_q] <= s_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= head_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ----- sv/atsm_back.sv -----
// Back end: executes loads into the stores and runs the score, weight and output passes.
// Depends on atsm_pkg and atsm_ram.
module atsm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  atsm_pkg::cmd_t      cmd,
	output logic                m_valid,
	input  logic                m_ready,
	output logic [1:0]          out_row,
	output logic [5:0]          out_col,
	output logic signed [15:0]  out_value,
	output logic                out_last
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_SCORE, ST_SCORE_DRAIN, ST_WEIGHT, ST_WEIGHT_DRAIN,
		ST_ACC, ST_ACC_DRAIN, ST_DIV, ST_EMIT
	} state_t;

	localparam logic [5:0] HD_LAST = 6'(atsm_pkg::HEAD_DIM - 1);
	localparam logic [5:0] KR_LAST = 6'(atsm_pkg::KEY_ROWS - 1);

	state_t state_q;
	logic [5:0] row_q, jc_q, dc_q, col_q;
	logic v_s1, v_s2, v_s3, v_s4, last_s1, last_s2;
	logic [5:0] j_s1, j_s2, j_s3, j_s4;
	logic [4:0] div_cnt_q;
	logic m_valid_q;

	logic q_we, k_we, v_we, s_we, w_we;
	logic [atsm_pkg::QS_AW-1:0] q_waddr, q_raddr;
	logic [atsm_pkg::KS_AW-1:0] kv_waddr, k_raddr, v_raddr;
	logic [15:0] q_rdata, k_rdata, v_rdata, w_rdata;
	logic [atsm_pkg::SCORE_W-1:0] s_rdata;

	logic issue, score_ph, wgt_ph, acc_ph, pipe_busy, can_emit, drain_done;
	logic signed [16:0] mul_a;
	logic signed [15:0] mul_b;
	logic signed [32:0] mul_p, prod_s2;
	logic signed [atsm_pkg::ACC_W-1:0] acc_q, acc_sum, max_q;
	logic signed [atsm_pkg::SCORE_W-1:0] diff;
	logic [28:0] x_s2;
	logic big_s2, zero_s3, zero_s4;
	logic [44:0] y_s3;
	logic [16:0] tk, tk1, tk_s4, m_val;
	logic [11:0] tdiff;
	logic [23:0] dp_s4;
	logic [5:0] n_s4;
	logic [17:0] rnd;
	logic [15:0] wv;
	logic [atsm_pkg::SUM_W-1:0] sum_q;
	logic [atsm_pkg::ACC_W-1:0] mag;
	logic [atsm_pkg::DIV_W-1:0] rem_q, dd_q;
	logic [atsm_pkg::QUOT_W-1:0] quot_q;
	logic neg_q, ge;
	logic signed [15:0] res_val;

	assign issue = state_q == ST_SCORE || state_q == ST_WEIGHT || state_q == ST_ACC;
	assign score_ph = state_q == ST_SCORE || state_q == ST_SCORE_DRAIN;
	assign wgt_ph = state_q == ST_WEIGHT || state_q == ST_WEIGHT_DRAIN;
	assign acc_ph = state_q == ST_ACC || state_q == ST_ACC_DRAIN;
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;
	assign drain_done = !pipe_busy;
	assign can_emit = !m_valid_q || m_ready;
	assign cmd_ready = state_q == ST_IDLE;

	assign q_we = cmd_ready && cmd_valid && cmd.mode == atsm_pkg::MODE_LOAD_Q;
	assign k_we = cmd_ready && cmd_valid && cmd.mode == atsm_pkg::MODE_LOAD_K;
	assign v_we = cmd_ready && cmd_valid && cmd.mode == atsm_pkg::MODE_LOAD_V;
	assign q_waddr = atsm_pkg::QS_AW'(32'(cmd.row) * atsm_pkg::HEAD_DIM + 32'(cmd.col));
	assign kv_waddr = atsm_pkg::KS_AW'(32'(cmd.row) * atsm_pkg::HEAD_DIM + 32'(cmd.col));
	assign q_raddr = atsm_pkg::QS_AW'(32'(row_q) * atsm_pkg::HEAD_DIM + 32'(dc_q));
	assign k_raddr = atsm_pkg::KS_AW'(32'(jc_q) * atsm_pkg::HEAD_DIM + 32'(dc_q));
	assign v_raddr = atsm_pkg::KS_AW'(32'(jc_q) * atsm_pkg::HEAD_DIM + 32'(col_q));

	atsm_ram #(.WIDTH(16), .DEPTH(atsm_pkg::QS_DEPTH)) u_qram (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(cmd.value),
		.raddr(q_raddr), .rdata(q_rdata));
	atsm_ram #(.WIDTH(16), .DEPTH(atsm_pkg::KS_DEPTH)) u_kram (
		.clk(clk), .we(k_we), .waddr(kv_waddr), .wdata(cmd.value),
		.raddr(k_raddr), .rdata(k_rdata));
	atsm_ram #(.WIDTH(16), .DEPTH(atsm_pkg::KS_DEPTH)) u_vram (
		.clk(clk), .we(v_we), .waddr(kv_waddr), .wdata(cmd.value),
		.raddr(v_raddr), .rdata(v_rdata));
	atsm_ram #(.WIDTH(atsm_pkg::SCORE_W), .DEPTH(atsm_pkg::BUF_DEPTH)) u_sram (
		.clk(clk), .we(s_we), .waddr(j_s2), .wdata(acc_sum),
		.raddr(jc_q), .rdata(s_rdata));
	atsm_ram #(.WIDTH(atsm_pkg::WEIGHT_W), .DEPTH(atsm_pkg::BUF_DEPTH)) u_wram (
		.clk(clk), .we(w_we), .waddr(j_s4), .wdata(wv),
		.raddr(jc_q), .rdata(w_rdata));

	assign mul_a = score_ph ? 17'(signed'(q_rdata)) : signed'({1'b0, w_rdata});
	assign mul_b = score_ph ? signed'(k_rdata) : signed'(v_rdata);
	assign mul_p = mul_a * mul_b;
	assign acc_sum = acc_q + {{(atsm_pkg::ACC_W - 33){prod_s2[32]}}, prod_s2};
	assign s_we = score_ph && v_s2 && last_s2;
	assign diff = max_q - signed'(s_rdata);

	assign tk = atsm_pkg::exp2_tab({1'b0, y_s3[38:35]});
	assign tk1 = atsm_pkg::exp2_tab(5'({1'b0, y_s3[38:35]} + 5'd1));
	assign tdiff = 12'(tk - tk1);
	assign m_val = tk_s4 - 17'(dp_s4 >> 12);
	assign rnd = (18'(m_val) + (18'd1 << (n_s4 - 6'd1))) >> n_s4;

	always_comb begin
		if (zero_s4 || n_s4 > 6'd17) begin
			wv = '0;
		end else if (n_s4 == 6'd0) begin
			wv = m_val[16] ? 16'hFFFF : m_val[15:0];
		end else begin
			wv = rnd[15:0];
		end
	end
	assign w_we = wgt_ph && v_s4;

	assign mag = acc_q[atsm_pkg::ACC_W-1] ? atsm_pkg::ACC_W'(-acc_q) : atsm_pkg::ACC_W'(acc_q);
	assign ge = rem_q >= dd_q;

	always_comb begin
		if (neg_q) begin
			res_val = (quot_q > 17'd32768) ? 16'sh8000 : 16'(-signed'({1'b0, quot_q}));
		end else begin
			res_val = (quot_q > 17'd32767) ? 16'sh7FFF : signed'(quot_q[15:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= '0;
			jc_q <= '0;
			dc_q <= '0;
			col_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
			div_cnt_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && can_emit) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
			v_s1 <= issue;
			last_s1 <= issue && (state_q == ST_SCORE ? dc_q == HD_LAST : jc_q == KR_LAST);
			v_s2 <= v_s1;
			last_s2 <= last_s1;
			v_s3 <= v_s2 && wgt_ph;
			v_s4 <= v_s3;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid && cmd.mode == atsm_pkg::MODE_COMPUTE) begin
						row_q <= cmd.row;
						jc_q <= '0;
						dc_q <= '0;
						state_q <= ST_SCORE;
					end
				end
				ST_SCORE: begin
					if (dc_q == HD_LAST) begin
						dc_q <= '0;
						if (jc_q == KR_LAST) begin
							jc_q <= '0;
							state_q <= ST_SCORE_DRAIN;
						end else begin
							jc_q <= jc_q + 6'd1;
						end
					end else begin
						dc_q <= dc_q + 6'd1;
					end
				end
				ST_SCORE_DRAIN: begin
					if (drain_done) begin
						state_q <= ST_WEIGHT;
					end
				end
				ST_WEIGHT, ST_ACC: begin
					if (jc_q == KR_LAST) begin
						jc_q <= '0;
						state_q <= (state_q == ST_WEIGHT) ? ST_WEIGHT_DRAIN : ST_ACC_DRAIN;
					end else begin
						jc_q <= jc_q + 6'd1;
					end
				end
				ST_WEIGHT_DRAIN: begin
					if (drain_done) begin
						col_q <= '0;
						state_q <= ST_ACC;
					end
				end
				ST_ACC_DRAIN: begin
					if (drain_done) begin
						div_cnt_q <= 5'(atsm_pkg::QUOT_W - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == '0) begin
						state_q <= ST_EMIT;
					end else begin
						div_cnt_q <= div_cnt_q - 5'd1;
					end
				end
				ST_EMIT: begin
					if (can_emit) begin
						if (col_q == HD_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							col_q <= col_q + 6'd1;
							state_q <= ST_ACC;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= jc_q;
		j_s2 <= j_s1;
		j_s3 <= j_s2;
		j_s4 <= j_s3;
		prod_s2 <= mul_p;
		x_s2 <= diff[28:0];
		big_s2 <= $unsigned(diff) >= atsm_pkg::EXP_LIMIT;
		y_s3 <= 45'(x_s2) * 45'(atsm_pkg::LOG2E_Q15);
		zero_s3 <= big_s2;
		zero_s4 <= zero_s3;
		n_s4 <= y_s3[44:39];
		tk_s4 <= tk;
		dp_s4 <= 24'(tdiff) * 24'(y_s3[34:23]);
		if (cmd_ready && cmd_valid && cmd.mode == atsm_pkg::MODE_COMPUTE) begin
			acc_q <= '0;
		end
		if (score_ph && v_s2) begin
			acc_q <= last_s2 ? '0 : acc_sum;
			if (last_s2 && (j_s2 == 6'd0 || acc_sum > max_q)) begin
				max_q <= acc_sum;
			end
		end
		if (state_q == ST_SCORE_DRAIN && drain_done) begin
			sum_q <= '0;
		end
		if (w_we) begin
			sum_q <= sum_q + atsm_pkg::SUM_W'(wv);
		end
		if ((state_q == ST_WEIGHT_DRAIN && drain_done) || (state_q == ST_EMIT && can_emit)) begin
			acc_q <= '0;
		end
		if (acc_ph && v_s2) begin
			acc_q <= acc_sum;
		end
		if (state_q == ST_ACC_DRAIN && drain_done) begin
			neg_q <= acc_q[atsm_pkg::ACC_W-1];
			rem_q <= (atsm_pkg::DIV_W'(mag) << 1) + atsm_pkg::DIV_W'(sum_q);
			dd_q <= atsm_pkg::DIV_W'(sum_q) << atsm_pkg::QUOT_W;
			quot_q <= '0;
		end
		if (state_q == ST_DIV) begin
			if (ge) begin
				rem_q <= rem_q - dd_q;
			end
			quot_q <= {quot_q[atsm_pkg::QUOT_W-2:0], ge};
			dd_q <= dd_q >> 1;
		end
		if (state_q == ST_EMIT && can_emit) begin
			out_row <= row_q[1:0];
			out_col <= col_q;
			out_value <= res_val;
			out_last <= col_q == HD_LAST;
		end
	end

	assign m_valid = m_valid_q;
endmodule

// ----- sv/attention_tile_softmax.sv -----
// Top level of the attention softmax tile: stream ports, front end and back end.
// Depends on atsm_pkg, atsm_front, atsm_back and assert_macros.svh.
// Load transactions (query, key or value element) are taken one per cycle while
// the front-end queue has room; each one in range writes one store entry. A
// compute transaction shares a single 17x16 multiplier between the score and
// output passes. It computes the scores, then the weights, then for each output
// column a weighted sum and a 17-bit bit-serial divide; emitting stalls while
// the output is not accepted. Loads queue up to four deep behind a running
// compute. The stores have no reset; read only entries that were written.
`include "assert_macros.svh"
module attention_tile_softmax (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // row[5:0], col[11:6], value[27:12], zero[31:28]
	input  logic [1:0]  s_axis_tuser,  // mode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // out_row[1:0], out_col[7:2], out_value[23:8]
	output logic        m_axis_tlast
);
	atsm_pkg::cmd_t s_cmd, cmd;
	logic cmd_valid, cmd_ready;
	logic [1:0] out_row;
	logic [5:0] out_col;
	logic signed [15:0] out_value;

	assign s_cmd.mode = atsm_pkg::mode_t'(s_axis_tuser);
	assign s_cmd.row = s_axis_tdata[5:0];
	assign s_cmd.col = s_axis_tdata[11:6];
	assign s_cmd.value = s_axis_tdata[27:12];

	atsm_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_cmd(s_cmd),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

	atsm_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
		.out_row(out_row), .out_col(out_col), .out_value(out_value),
		.out_last(m_axis_tlast));

	assign m_axis_tdata = {out_value, out_col, out_row};

	`ASSERT_NEXT(a_compute_blocks, clk, arst_n, cmd_valid && cmd_ready && cmd.mode == atsm_pkg::MODE_COMPUTE, !cmd_ready)
	`ASSERT_IMPL(a_mid_row_busy, clk, arst_n, $rose(m_axis_tvalid) && !m_axis_tlast, !cmd_ready)
	`ASSERT_IMPL(a_full_not_empty, clk, arst_n, !s_axis_tready, cmd_valid)
endmodule
